// File: rtl/core/yee_fdtd_grid_step_assert.svh
// ----------------------------------------------------------------------------
// yee_fdtd_grid_step assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef YEE_FDTD_GRID_STEP_ASSERT_SVH
`define YEE_FDTD_GRID_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define YSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ysg assertion failed");
// next-cycle implication
`define YSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ysg assertion failed");
`else
`define YSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define YSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ysg_pkg.sv
// ----------------------------------------------------------------------------
// ysg_pkg
// Shared types and constants of the Yee grid update engine.
// ----------------------------------------------------------------------------
package ysg_pkg;

    localparam int FIELD_W   = 32;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam int AXIS_W    = 5;
    localparam int DIM_W     = 6;
    localparam int COMP_W    = 3;
    localparam int ADDR_W    = 18;
    localparam int MEM_DEPTH = 196608;
    localparam int MAX_AXIS  = 32;
    localparam int DIFF_W    = FIELD_W + 1;
    localparam int PROD_W    = COEF_W + DIFF_W;
    localparam int ACC_W     = PROD_W + 2;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_STEP = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_UPD,
        ST_FRC,
        ST_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        MAC_IDLE,
        MAC_OLD,
        MAC_BASE,
        MAC_D1,
        MAC_BASE2,
        MAC_D2,
        MAC_ACC,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        t_mac_op op;
        logic    fwd;
    } t_mac_ctl;

    typedef struct packed {
        logic                     mark;
        logic signed [COEF_W-1:0] self_coef;
        logic signed [COEF_W-1:0] first;
        logic signed [COEF_W-1:0] second;
    } t_param;

endpackage

// File: rtl/core/ysg_ram.sv
// ----------------------------------------------------------------------------
// ysg_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module ysg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 196608
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/ysg_mac.sv
// ----------------------------------------------------------------------------
// ysg_mac
// Node update datapath: neighbor differences, one shared multiplier,
// accumulator, shift and saturation.
// ----------------------------------------------------------------------------
module ysg_mac (
    input  logic                                    i_clk,
    input  ysg_pkg::t_mac_ctl                       i_ctl,
    input  logic signed [ysg_pkg::FIELD_W-1:0]      i_field,
    input  ysg_pkg::t_param                         i_par,
    output logic signed [ysg_pkg::FIELD_W-1:0]      o_result
);
    import ysg_pkg::*;

    localparam int SH_W = ACC_W - COEF_FRAC;

    logic signed [FIELD_W-1:0] r_old;
    logic signed [FIELD_W-1:0] r_base;
    logic signed [COEF_W-1:0]  r_self;
    logic signed [COEF_W-1:0]  r_first;
    logic signed [COEF_W-1:0]  r_second;
    logic signed [DIFF_W-1:0]  r_d1;
    logic signed [DIFF_W-1:0]  r_d2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [COEF_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SH_W-1:0]    sh;

    // neighbor difference, forward for H and backward for E
    always_comb begin
        if (i_ctl.fwd) begin
            diff = DIFF_W'(i_field) - DIFF_W'(r_base);
        end else begin
            diff = DIFF_W'(r_base) - DIFF_W'(i_field);
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = r_self;
        mul_b = DIFF_W'(r_old);
        case (i_ctl.op)
            MAC_D2:  begin mul_a = r_first;  mul_b = r_d1; end
            MAC_ACC: begin mul_a = r_second; mul_b = r_d2; end
            default: begin mul_a = r_self;   mul_b = DIFF_W'(r_old); end
        endcase
    end

    // operand capture, product and accumulation
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_ctl.op)
            MAC_OLD: begin
                r_old    <= i_field;
                r_self   <= i_par.self_coef;
                r_first  <= i_par.first;
                r_second <= i_par.second;
            end
            MAC_BASE, MAC_BASE2: r_base <= i_field;
            MAC_D1:  r_d1 <= diff;
            MAC_D2: begin
                r_d2  <= diff;
                r_acc <= ACC_W'(r_prod);
            end
            MAC_ACC: r_acc <= r_acc + ACC_W'(r_prod);
            MAC_SUB: r_acc <= r_acc - ACC_W'(r_prod);
            default: ;
        endcase
    end

    // floor shift and saturation to the field width
    always_comb begin
        sh = r_acc[ACC_W-1:COEF_FRAC];
        if ((&sh[SH_W-1:FIELD_W-1]) || !(|sh[SH_W-1:FIELD_W-1])) begin
            o_result = sh[FIELD_W-1:0];
        end else if (sh[SH_W-1]) begin
            o_result = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(FIELD_W-1){1'b1}}};
        end
    end

endmodule

// File: rtl/core/yee_fdtd_grid_step.sv
// Yee grid update engine. After reset the block sweeps the coefficient memory
// once to clear the source marks, and accepts no word until then. Loads stream
// at one per cycle while result words are accepted; a read passes through the
// registered field memory port. A step walks the grid: each interior node of
// each of the six components is updated with five reads through the single
// field memory read port and three passes of the shared multiplier, then
// written back, and a component with no interior node is skipped; then every
// node of Ez, Ey and Ex is visited for the source forcing, and a drain state
// writes the last forced node. Every result word waits in one output register,
// and no new word is taken while that register holds a word not yet accepted.
// ----------------------------------------------------------------------------
// yee_fdtd_grid_step
// Top level: configuration, request sequencer, memories and result register.
// ----------------------------------------------------------------------------
`include "yee_fdtd_grid_step_assert.svh"

module yee_fdtd_grid_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_component,
    input  logic [4:0]  i_node_i,
    input  logic [4:0]  i_node_j,
    input  logic [4:0]  i_node_k,
    input  logic signed [31:0] i_self_coef,
    input  logic signed [31:0] i_curl_coef_first,
    input  logic signed [31:0] i_curl_coef_second,
    input  logic signed [31:0] i_initial_field,
    input  logic        i_is_source,
    input  logic signed [31:0] i_drive_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_read_field,
    output logic        o_status
);
    import ysg_pkg::*;

    localparam logic [COMP_W-1:0] COMP_EX = 3'd0;
    localparam logic [COMP_W-1:0] COMP_EZ = 3'd2;
    localparam logic [COMP_W-1:0] COMP_HX = 3'd3;
    localparam logic [COMP_W-1:0] COMP_HZ = 3'd5;
    localparam logic [COMP_W-1:0] COMP_CNT = 3'd6;
    localparam logic [1:0] CFG_M = 2'd0;
    localparam logic [1:0] CFG_N = 2'd1;
    localparam logic [1:0] CFG_P = 2'd2;
    localparam logic [3:0] PH_WRITE = 4'd8;

    typedef struct packed {
        logic [COMP_W-1:0] f1;
        logic [1:0]        a1;
        logic [COMP_W-1:0] f2;
        logic [1:0]        a2;
    } t_plan;

    // axes shortened by one: bit 0 x, bit 1 y, bit 2 z
    function automatic logic [2:0] short_axes(input logic [COMP_W-1:0] c);
        case (c)
            3'd0:    return 3'b001;
            3'd1:    return 3'b010;
            3'd2:    return 3'b100;
            3'd3:    return 3'b110;
            3'd4:    return 3'b101;
            3'd5:    return 3'b011;
            default: return 3'b000;
        endcase
    endfunction

    // curl sources and difference axes per component
    function automatic t_plan plan_of(input logic [COMP_W-1:0] c);
        case (c)
            3'd0:    return '{f1: 3'd5, a1: 2'd1, f2: 3'd4, a2: 2'd2};
            3'd1:    return '{f1: 3'd3, a1: 2'd2, f2: 3'd5, a2: 2'd0};
            3'd2:    return '{f1: 3'd4, a1: 2'd0, f2: 3'd3, a2: 2'd1};
            3'd3:    return '{f1: 3'd1, a1: 2'd2, f2: 3'd2, a2: 2'd1};
            3'd4:    return '{f1: 3'd2, a1: 2'd0, f2: 3'd0, a2: 2'd2};
            default: return '{f1: 3'd0, a1: 2'd1, f2: 3'd1, a2: 2'd0};
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] s);
        if (s < DIM_W'(2)) return DIM_W'(2);
        else if (s > DIM_W'(MAX_AXIS)) return DIM_W'(MAX_AXIS);
        else return s;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COMP_W-1:0] c,
            input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
            input logic [AXIS_W-1:0] z);
        return {c, z, y, x};
    endfunction

    // neighbor address one step along an axis
    function automatic logic [ADDR_W-1:0] nbr_of(input logic [COMP_W-1:0] c,
            input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
            input logic [AXIS_W-1:0] z, input logic [1:0] axis, input logic fwd);
        logic [AXIS_W-1:0] d;
        logic [AXIS_W-1:0] nx;
        logic [AXIS_W-1:0] ny;
        logic [AXIS_W-1:0] nz;
        d  = fwd ? AXIS_W'(1) : {AXIS_W{1'b1}};
        nx = x;
        ny = y;
        nz = z;
        case (axis)
            2'd0:    nx = x + d;
            2'd1:    ny = y + d;
            default: nz = z + d;
        endcase
        return {c, nz, ny, nx};
    endfunction

    // control registers
    t_state            r_state, n_state;
    logic [3:0]        r_ph, n_ph;
    logic [COMP_W-1:0] r_comp, n_comp;
    logic [AXIS_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [DIM_W-1:0]  r_size_m, r_size_n, r_size_p;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status;
    logic signed [FIELD_W-1:0] r_out_field;
    logic signed [FIELD_W-1:0] r_drive;
    logic              r_frc_pend;
    logic [ADDR_W-1:0] r_frc_addr;
    logic signed [FIELD_W-1:0] r_frc_val;

    // memory and datapath signals
    logic              fld_we;
    logic [ADDR_W-1:0] fld_waddr, fld_raddr;
    logic signed [FIELD_W-1:0] fld_wdata, fld_rdata;
    logic              par_we;
    logic [ADDR_W-1:0] par_waddr, par_raddr;
    t_param            par_wdata, par_rdata;
    t_mac_ctl          mac_ctl;
    logic signed [FIELD_W-1:0] mac_result;

    logic              in_acc;
    logic              in_ok;
    logic [DIM_W-1:0]  cm, cn, cp;
    logic [DIM_W-1:0]  in_di, in_dj, in_dk;
    logic [DIM_W-1:0]  di, dj, dk;
    logic [2:0]        in_short, cur_short;
    t_plan             plan;
    logic              upd_fwd;
    logic              upd_empty;
    logic [ADDR_W-1:0] own_addr, in_addr;

    // grid dimensions of the requested and the current component
    always_comb begin
        cm        = clamp_size(r_size_m);
        cn        = clamp_size(r_size_n);
        cp        = clamp_size(r_size_p);
        in_short  = short_axes(i_component);
        cur_short = short_axes(r_comp);
        in_di     = cm - DIM_W'(in_short[0]);
        in_dj     = cn - DIM_W'(in_short[1]);
        in_dk     = cp - DIM_W'(in_short[2]);
        di        = cm - DIM_W'(cur_short[0]);
        dj        = cn - DIM_W'(cur_short[1]);
        dk        = cp - DIM_W'(cur_short[2]);
        in_ok     = (i_component < COMP_CNT) && ({1'b0, i_node_i} < in_di)
                    && ({1'b0, i_node_j} < in_dj) && ({1'b0, i_node_k} < in_dk);
        plan      = plan_of(r_comp);
        upd_fwd   = (r_comp >= COMP_HX);
        upd_empty = (di < DIM_W'(3)) || (dj < DIM_W'(3)) || (dk < DIM_W'(3));
        own_addr  = addr_of(r_comp, r_i, r_j, r_k);
        in_addr   = addr_of(i_component, i_node_i, i_node_j, i_node_k);
    end

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_comp  = r_comp;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_req'(i_req_type))
                        REQ_STEP: begin
                            n_state = ST_UPD;
                            n_comp  = COMP_HX;
                            n_ph    = 4'd0;
                            n_i     = AXIS_W'(1);
                            n_j     = AXIS_W'(1);
                            n_k     = AXIS_W'(1);
                        end
                        REQ_READ: begin
                            if (in_ok) begin
                                n_state = ST_RD_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: n_state = ST_IDLE;
            ST_UPD: begin
                if ((r_ph == 4'd0 && upd_empty) || r_ph == PH_WRITE) begin
                    n_ph = 4'd0;
                    if (r_ph == PH_WRITE && ({1'b0, r_i} + DIM_W'(2)) < di) begin
                        n_i = r_i + AXIS_W'(1);
                    end else if (r_ph == PH_WRITE && ({1'b0, r_j} + DIM_W'(2)) < dj) begin
                        n_i = AXIS_W'(1);
                        n_j = r_j + AXIS_W'(1);
                    end else if (r_ph == PH_WRITE && ({1'b0, r_k} + DIM_W'(2)) < dk) begin
                        n_i = AXIS_W'(1);
                        n_j = AXIS_W'(1);
                        n_k = r_k + AXIS_W'(1);
                    end else if (r_comp == COMP_EZ) begin
                        // all components updated, start forcing sources
                        n_state = ST_FRC;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                    end else begin
                        n_comp = (r_comp == COMP_HZ) ? COMP_EX : r_comp + COMP_W'(1);
                        n_i    = AXIS_W'(1);
                        n_j    = AXIS_W'(1);
                        n_k    = AXIS_W'(1);
                    end
                end else begin
                    n_ph = r_ph + 4'd1;
                end
            end
            ST_FRC: begin
                if (({1'b0, r_i} + DIM_W'(1)) < di) begin
                    n_i = r_i + AXIS_W'(1);
                end else if (({1'b0, r_j} + DIM_W'(1)) < dj) begin
                    n_i = '0;
                    n_j = r_j + AXIS_W'(1);
                end else if (({1'b0, r_k} + DIM_W'(1)) < dk) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = r_k + AXIS_W'(1);
                end else if (r_comp == COMP_EX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_comp = r_comp - COMP_W'(1);
                    n_i    = '0;
                    n_j    = '0;
                    n_k    = '0;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls and datapath sequencing
    always_comb begin
        fld_we    = 1'b0;
        fld_waddr = own_addr;
        fld_wdata = mac_result;
        fld_raddr = own_addr;
        par_we    = 1'b0;
        par_waddr = in_addr;
        par_wdata = '{mark: i_is_source, self_coef: i_self_coef,
                      first: i_curl_coef_first, second: i_curl_coef_second};
        par_raddr = own_addr;
        mac_ctl   = '{op: MAC_IDLE, fwd: upd_fwd};
        case (r_state)
            ST_CLEAR: begin
                par_we    = 1'b1;
                par_waddr = r_clr;
                par_wdata = '0;
            end
            ST_IDLE: begin
                fld_raddr = in_addr;
                fld_waddr = in_addr;
                fld_wdata = i_initial_field;
                if (in_acc && t_req'(i_req_type) == REQ_LOAD && in_ok) begin
                    fld_we = 1'b1;
                    par_we = 1'b1;
                end
            end
            ST_UPD: begin
                case (r_ph)
                    4'd1: fld_raddr = addr_of(plan.f1, r_i, r_j, r_k);
                    4'd2: fld_raddr = nbr_of(plan.f1, r_i, r_j, r_k, plan.a1, upd_fwd);
                    4'd3: fld_raddr = addr_of(plan.f2, r_i, r_j, r_k);
                    4'd4: fld_raddr = nbr_of(plan.f2, r_i, r_j, r_k, plan.a2, upd_fwd);
                    default: fld_raddr = own_addr;
                endcase
                case (r_ph)
                    4'd1:    mac_ctl.op = MAC_OLD;
                    4'd2:    mac_ctl.op = MAC_BASE;
                    4'd3:    mac_ctl.op = MAC_D1;
                    4'd4:    mac_ctl.op = MAC_BASE2;
                    4'd5:    mac_ctl.op = MAC_D2;
                    4'd6:    mac_ctl.op = MAC_ACC;
                    4'd7:    mac_ctl.op = MAC_SUB;
                    default: mac_ctl.op = MAC_IDLE;
                endcase
                fld_we = (r_ph == PH_WRITE);
            end
            ST_FRC, ST_DRAIN: begin
                fld_waddr = r_frc_addr;
                fld_wdata = r_frc_val;
                fld_we    = r_frc_pend && par_rdata.mark;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_ph       <= '0;
            r_comp     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_clr      <= '0;
            r_frc_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ph       <= n_ph;
            r_comp     <= n_comp;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_clr      <= n_clr;
            r_frc_pend <= (r_state == ST_FRC);
        end
    end

    // pending source write, issued in the cycle after the mark read
    always_ff @(posedge i_clk) begin
        r_frc_addr <= own_addr;
        r_frc_val  <= (r_comp == COMP_EZ) ? r_drive : '0;
    end

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m <= DIM_W'(MAX_AXIS);
            r_size_n <= DIM_W'(MAX_AXIS);
            r_size_p <= DIM_W'(MAX_AXIS);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_M:   r_size_m <= i_cfg_data;
                CFG_N:   r_size_n <= i_cfg_data;
                CFG_P:   r_size_p <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result word valid, next value
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_req'(i_req_type))
                        REQ_LOAD: n_out_valid = 1'b1;
                        REQ_READ: n_out_valid = !in_ok;
                        REQ_NONE: n_out_valid = 1'b1;
                        default:  ;
                    endcase
                end
            end
            ST_RD_WAIT, ST_DRAIN: n_out_valid = 1'b1;
            default: ;
        endcase
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload and drive sample
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_out_field <= '0;
                    r_drive     <= i_drive_sample;
                    case (t_req'(i_req_type))
                        REQ_LOAD, REQ_READ: r_out_status <= !in_ok;
                        REQ_NONE:           r_out_status <= 1'b1;
                        default:            r_out_status <= 1'b0;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                r_out_field  <= fld_rdata;
                r_out_status <= 1'b0;
            end
            ST_DRAIN: begin
                r_out_field  <= '0;
                r_out_status <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_field = r_out_field;
    assign o_status     = r_out_status;

    // field values
    ysg_ram #(
        .WIDTH (32),
        .DEPTH (196608)
    ) u_field_mem (
        .i_clk   (i_clk),
        .i_we    (fld_we),
        .i_waddr (fld_waddr),
        .i_wdata (fld_wdata),
        .i_raddr (fld_raddr),
        .o_rdata (fld_rdata)
    );

    // coefficients and source marks
    ysg_ram #(
        .WIDTH (97),
        .DEPTH (196608)
    ) u_param_mem (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    // update arithmetic
    ysg_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_field  (fld_rdata),
        .i_par    (par_rdata),
        .o_result (mac_result)
    );

    // checks
    `YSG_ASSERT_IMP(a_no_field_write_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !fld_we)
    `YSG_ASSERT_IMP(a_upd_phase_range, i_clk, i_rst_n, r_state == ST_UPD, r_ph <= PH_WRITE)
    `YSG_ASSERT_IMP(a_upd_writes_back, i_clk, i_rst_n, r_state == ST_UPD && r_ph == PH_WRITE, fld_we)
    `YSG_ASSERT_NXT(a_step_gives_result, i_clk, i_rst_n, r_state == ST_DRAIN, r_out_valid)

endmodule

// File: tb/tb_yee_fdtd_grid_step.sv
// ----------------------------------------------------------------------------
// tb_yee_fdtd_grid_step
// Self-checking bench for the Yee grid update engine: a directed table of
// loads, reads, rejects and source steps, then random phases over many grid
// sizes, each checked word by word against a behavioral grid predictor.
// ----------------------------------------------------------------------------
module tb_yee_fdtd_grid_step;
    timeunit 1ns;
    timeprecision 1ps;

    import ysg_pkg::*;

    localparam logic [2:0] C_EX = 3'd0;
    localparam logic [2:0] C_EY = 3'd1;
    localparam logic [2:0] C_EZ = 3'd2;
    localparam logic [2:0] C_HX = 3'd3;
    localparam logic [2:0] C_HY = 3'd4;
    localparam logic [2:0] C_HZ = 3'd5;
    localparam logic [2:0] C_BAD6 = 3'd6;
    localparam logic [2:0] C_BAD7 = 3'd7;

    localparam logic [1:0] CFG_SIZE_M = 2'd0;
    localparam logic [1:0] CFG_SIZE_N = 2'd1;
    localparam logic [1:0] CFG_SIZE_P = 2'd2;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    localparam int PLANE = 32768;
    localparam int ITEM_TARGET = 1550;

    // axes shortened per component, bit 0 x, bit 1 y, bit 2 z
    localparam bit [2:0] SHORTS [6] = '{3'b001, 3'b010, 3'b100, 3'b110, 3'b101, 3'b011};
    // first neighbor component, its axis, second component, its axis
    localparam int CURL [6][4] = '{'{5, 1, 4, 2}, '{3, 2, 5, 0}, '{4, 0, 3, 1},
                                   '{1, 2, 2, 1}, '{2, 0, 0, 2}, '{0, 1, 1, 0}};

    typedef struct {
        t_req               req;
        logic [2:0]         comp;
        logic [4:0]         ni;
        logic [4:0]         nj;
        logic [4:0]         nk;
        logic signed [31:0] own_c;
        logic signed [31:0] first_c;
        logic signed [31:0] second_c;
        logic signed [31:0] init_f;
        logic               src;
        logic signed [31:0] drive;
    } t_word;

    typedef struct {
        logic signed [31:0] field;
        logic               status;
    } t_result;

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_idx;
        logic [5:0] cfg_val;
        t_word      w;
        bit         has_exp;
        t_result    exp_r;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    logic [5:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic [2:0]         i_component;
    logic [4:0]         i_node_i;
    logic [4:0]         i_node_j;
    logic [4:0]         i_node_k;
    logic signed [31:0] i_self_coef;
    logic signed [31:0] i_curl_coef_first;
    logic signed [31:0] i_curl_coef_second;
    logic signed [31:0] i_initial_field;
    logic               i_is_source;
    logic signed [31:0] i_drive_sample;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_read_field;
    logic               o_status;

    yee_fdtd_grid_step DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_component        (i_component),
        .i_node_i           (i_node_i),
        .i_node_j           (i_node_j),
        .i_node_k           (i_node_k),
        .i_self_coef        (i_self_coef),
        .i_curl_coef_first  (i_curl_coef_first),
        .i_curl_coef_second (i_curl_coef_second),
        .i_initial_field    (i_initial_field),
        .i_is_source        (i_is_source),
        .i_drive_sample     (i_drive_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_field       (o_read_field),
        .o_status           (o_status)
    );

    // grid shadow state
    logic signed [31:0] grid_field [PLANE*6];
    logic signed [31:0] grid_own   [PLANE*6];
    logic signed [31:0] grid_first [PLANE*6];
    logic signed [31:0] grid_second[PLANE*6];
    bit                 grid_mark  [PLANE*6];
    bit                 grid_loaded[PLANE*6];
    logic [5:0]         size_reg   [3];

    t_result pending_words[$];
    t_row    plan[$];
    int      mismatches;
    int      items_sent;
    bit      idle_on;
    bit      long_hold;

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // grid geometry
    function automatic int axis_size(int axis);
        int s;
        s = size_reg[axis];
        if (s < 2) s = 2;
        if (s > MAX_AXIS) s = MAX_AXIS;
        return s;
    endfunction

    function automatic int comp_dim(int c, int axis);
        return axis_size(axis) - (SHORTS[c][axis] ? 1 : 0);
    endfunction

    function automatic int node_addr(int c, int i, int j, int k);
        return c * PLANE + i + 32 * (j + 32 * k);
    endfunction

    function automatic bit in_comp(logic [2:0] c, int i, int j, int k);
        if (c > C_HZ) return 1'b0;
        return i < comp_dim(c, 0) && j < comp_dim(c, 1) && k < comp_dim(c, 2);
    endfunction

    // one leapfrog half step for a component, interior nodes only
    function automatic void advance_comp(int c);
        int f1, a1, f2, a2, me, nb1, nb2;
        int q[3];
        int p[3];
        bit fwd;
        longint d1, d2;
        logic signed [127:0] acc;
        f1 = CURL[c][0]; a1 = CURL[c][1]; f2 = CURL[c][2]; a2 = CURL[c][3];
        fwd = c >= 3;
        for (int k = 1; k + 1 < comp_dim(c, 2); k++)
            for (int j = 1; j + 1 < comp_dim(c, 1); j++)
                for (int i = 1; i + 1 < comp_dim(c, 0); i++) begin
                    q = '{i, j, k};
                    p = '{i, j, k};
                    q[a1] = fwd ? q[a1] + 1 : q[a1] - 1;
                    p[a2] = fwd ? p[a2] + 1 : p[a2] - 1;
                    me = node_addr(c, i, j, k);
                    nb1 = node_addr(f1, q[0], q[1], q[2]);
                    nb2 = node_addr(f2, p[0], p[1], p[2]);
                    d1 = longint'(grid_field[nb1]) - longint'(grid_field[node_addr(f1, i, j, k)]);
                    d2 = longint'(grid_field[nb2]) - longint'(grid_field[node_addr(f2, i, j, k)]);
                    if (!fwd) begin
                        d1 = -d1;
                        d2 = -d2;
                    end
                    acc = longint'(grid_own[me]) * longint'(grid_field[me])
                        + longint'(grid_first[me]) * d1
                        - longint'(grid_second[me]) * d2;
                    acc = acc >>> COEF_FRAC;
                    if (acc > 128'sd2147483647) grid_field[me] = 32'sh7FFF_FFFF;
                    else if (acc < -128'sd2147483648) grid_field[me] = 32'sh8000_0000;
                    else grid_field[me] = acc[31:0];
                end
    endfunction

    function automatic void force_marked(int c, logic signed [31:0] v);
        int at;
        for (int k = 0; k < comp_dim(c, 2); k++)
            for (int j = 0; j < comp_dim(c, 1); j++)
                for (int i = 0; i < comp_dim(c, 0); i++) begin
                    at = node_addr(c, i, j, k);
                    if (grid_mark[at]) grid_field[at] = v;
                end
    endfunction

    // predict the result of one accepted word and advance the shadow grid
    function automatic t_result grid_apply(t_word w);
        t_result r;
        bit ok;
        int at;
        r.field = '0;
        r.status = ST_DONE;
        ok = in_comp(w.comp, w.ni, w.nj, w.nk);
        at = ok ? node_addr(w.comp, w.ni, w.nj, w.nk) : 0;
        case (w.req)
            REQ_LOAD: begin
                if (ok) begin
                    grid_own[at] = w.own_c;
                    grid_first[at] = w.first_c;
                    grid_second[at] = w.second_c;
                    grid_field[at] = w.init_f;
                    grid_mark[at] = w.src;
                    grid_loaded[at] = 1'b1;
                end else begin
                    r.status = ST_REJECT;
                end
            end
            REQ_STEP: begin
                for (int c = 3; c < 6; c++) advance_comp(c);
                for (int c = 0; c < 3; c++) advance_comp(c);
                force_marked(C_EZ, w.drive);
                force_marked(C_EY, '0);
                force_marked(C_EX, '0);
            end
            REQ_READ: begin
                if (ok) r.field = grid_field[at];
                else r.status = ST_REJECT;
            end
            default: r.status = ST_REJECT;
        endcase
        return r;
    endfunction

    // drive one word and hold it until accepted
    task automatic send_word(t_word w, bit has_exp, t_result exp_r);
        t_result r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = w.req;
        i_component = w.comp;
        i_node_i = w.ni;
        i_node_j = w.nj;
        i_node_k = w.nk;
        i_self_coef = w.own_c;
        i_curl_coef_first = w.first_c;
        i_curl_coef_second = w.second_c;
        i_initial_field = w.init_f;
        i_is_source = w.src;
        i_drive_sample = w.drive;
        do @(posedge i_clk); while (!o_in_ready);
        r = grid_apply(w);
        pending_words.push_back(has_exp ? exp_r : r);
        items_sent++;
    endtask

    task automatic drain_words();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending_words.size() == 0);
    endtask

    task automatic write_size(logic [1:0] idx, logic [5:0] val);
        drain_words();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        size_reg[idx] = val;
    endtask

    // random payload values, mostly well-scaled with full-range ones mixed in
    function automatic t_word rand_word(t_req req, logic [2:0] c, int i, int j, int k);
        t_word w;
        w.req = req;
        w.comp = c;
        w.ni = 5'(i);
        w.nj = 5'(j);
        w.nk = 5'(k);
        w.src = $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 3) == 0) begin
            w.own_c = $urandom;
            w.first_c = $urandom;
            w.second_c = $urandom;
            w.init_f = $urandom;
            w.drive = $urandom;
        end else begin
            w.own_c = 32'h3FF0_0000 + $urandom_range(0, 32'h0020_0000);
            w.first_c = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            w.second_c = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            w.init_f = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            w.drive = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end
        return w;
    endfunction

    function automatic t_word pick_inside(t_req req);
        logic [2:0] c;
        c = 3'($urandom_range(0, 5));
        return rand_word(req, c, $urandom_range(0, comp_dim(c, 0) - 1),
                         $urandom_range(0, comp_dim(c, 1) - 1),
                         $urandom_range(0, comp_dim(c, 2) - 1));
    endfunction

    // load every node of the current grid so that steps touch only known data
    task automatic fill_grid();
        t_result none;
        none = '{default: '0};
        for (int c = 0; c < 6; c++)
            for (int k = 0; k < comp_dim(c, 2); k++)
                for (int j = 0; j < comp_dim(c, 1); j++)
                    for (int i = 0; i < comp_dim(c, 0); i++)
                        send_word(rand_word(REQ_LOAD, 3'(c), i, j, k), 1'b0, none);
    endtask

    // mixed loads, reads, steps and rejected words
    task automatic random_mix(int count, bit steps_ok);
        t_word w;
        t_result none;
        int sel;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                w = pick_inside(REQ_LOAD);
            end else if (sel < 80) begin
                w = pick_inside(REQ_READ);
                if (!grid_loaded[node_addr(w.comp, w.ni, w.nj, w.nk)]) w.req = REQ_LOAD;
            end else if (sel < 90 && steps_ok) begin
                w = rand_word(REQ_STEP, 3'($urandom), $urandom, $urandom, $urandom);
            end else begin
                // noise: random codes and positions, in-range reads of unloaded nodes turned into REQ_NONE
                w = rand_word(t_req'($urandom_range(0, 3)), 3'($urandom), $urandom, $urandom,
                              $urandom);
                if (w.req == REQ_STEP && !steps_ok) w.req = REQ_NONE;
                if (w.req == REQ_READ && in_comp(w.comp, w.ni, w.nj, w.nk)
                        && !grid_loaded[node_addr(w.comp, w.ni, w.nj, w.nk)])
                    w.req = REQ_NONE;
            end
            send_word(w, 1'b0, none);
        end
    endtask

    // build the directed table
    task automatic add_item(t_req req, logic [2:0] c, int i, int j, int k,
                            logic signed [31:0] init_f, logic src, logic signed [31:0] drive,
                            bit has_exp, logic signed [31:0] e_field, logic e_status);
        t_row row;
        row.is_cfg = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.w = rand_word(req, c, i, j, k);
        row.w.init_f = init_f;
        row.w.src = src;
        row.w.drive = drive;
        row.has_exp = has_exp;
        row.exp_r.field = e_field;
        row.exp_r.status = e_status;
        plan.push_back(row);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [5:0] val);
        t_row row;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.w = rand_word(REQ_NONE, C_EX, 0, 0, 0);
        row.has_exp = 1'b0;
        row.exp_r.field = '0;
        row.exp_r.status = ST_DONE;
        plan.push_back(row);
    endtask

    // receiver side: random stall bursts and one long hold-off
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: field %h status %b",
                             o_read_field, o_status);
            end else begin
                want = pending_words.pop_front();
                if (o_read_field !== want.field || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: field exp %h got %h, status exp %b got %b",
                                 want.field, o_read_field, want.status, o_status);
                end
            end
        end
    end

    // watchdog
    initial begin
        #(64'd40_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial begin
        t_result none;
        logic [5:0] phases [8][3];
        bit filled;
        int ph;
        none = '{default: '0};
        phases = '{'{6'd3, 6'd3, 6'd3}, '{6'd4, 6'd3, 6'd5}, '{6'd1, 6'd3, 6'd0},
                   '{6'd5, 6'd4, 6'd3}, '{6'd2, 6'd4, 6'd4}, '{6'd63, 6'd2, 6'd2},
                   '{6'd3, 6'd5, 6'd4}, '{6'd4, 6'd4, 6'd4}};
        mismatches = 0;
        items_sent = 0;
        idle_on = 1'b0;
        long_hold = 1'b0;
        size_reg = '{6'd32, 6'd32, 6'd32};
        foreach (grid_mark[n]) begin
            grid_mark[n] = 1'b0;
            grid_loaded[n] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_SIZE_M;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_req_type = REQ_NONE;
        i_component = C_EX;
        i_node_i = '0;
        i_node_j = '0;
        i_node_k = '0;
        i_self_coef = '0;
        i_curl_coef_first = '0;
        i_curl_coef_second = '0;
        i_initial_field = '0;
        i_is_source = 1'b0;
        i_drive_sample = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes at full size, rejects, then forcing on the smallest grid
        add_item(REQ_LOAD, C_EX, 0, 0, 0, 32'sh7FFF_FFFF, 1'b1, 0, 1, 0, ST_DONE);
        add_item(REQ_READ, C_EX, 0, 0, 0, 0, 0, 0, 1, 32'sh7FFF_FFFF, ST_DONE);
        add_item(REQ_LOAD, C_HZ, 30, 30, 31, 32'sh8000_0000, 1'b1, 0, 1, 0, ST_DONE);
        add_item(REQ_READ, C_HZ, 30, 30, 31, 0, 0, 0, 1, 32'sh8000_0000, ST_DONE);
        add_item(REQ_LOAD, C_EX, 31, 0, 0, 5, 0, 0, 1, 0, ST_REJECT);
        add_item(REQ_READ, C_EY, 0, 31, 0, 0, 0, 0, 1, 0, ST_REJECT);
        add_item(REQ_LOAD, C_EY, 31, 30, 31, 32'sh1234_5678, 0, 0, 1, 0, ST_DONE);
        add_item(REQ_READ, C_EY, 31, 30, 31, 0, 0, 0, 1, 32'sh1234_5678, ST_DONE);
        add_item(REQ_LOAD, C_BAD6, 0, 0, 0, 7, 1, 0, 1, 0, ST_REJECT);
        add_item(REQ_READ, C_BAD7, 0, 0, 0, 0, 0, 0, 1, 0, ST_REJECT);
        add_item(REQ_NONE, C_EX, 0, 0, 0, 0, 0, 0, 1, 0, ST_REJECT);
        add_item(REQ_LOAD, C_EZ, 31, 31, 30, -1, 1'b1, 0, 1, 0, ST_DONE);
        add_item(REQ_LOAD, C_HX, 31, 30, 30, 9, 1'b1, 0, 1, 0, ST_DONE);
        add_item(REQ_LOAD, C_HY, 30, 31, 30, -9, 1'b0, 0, 1, 0, ST_DONE);
        add_item(REQ_READ, C_HX, 31, 31, 30, 0, 0, 0, 1, 0, ST_REJECT);
        add_cfg(CFG_SIZE_M, 6'd2);
        add_cfg(CFG_SIZE_N, 6'd2);
        add_cfg(CFG_SIZE_P, 6'd2);
        add_item(REQ_STEP, C_EX, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1, 0, ST_DONE);
        add_item(REQ_READ, C_EX, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE);
        add_item(REQ_READ, C_HZ, 30, 30, 31, 0, 0, 0, 1, 0, ST_REJECT);
        add_item(REQ_LOAD, C_EZ, 1, 1, 0, 5, 1'b1, 0, 1, 0, ST_DONE);
        add_item(REQ_STEP, C_HZ, 0, 0, 0, 0, 0, 32'sh8000_0000, 1, 0, ST_DONE);
        add_item(REQ_READ, C_EZ, 1, 1, 0, 0, 0, 0, 1, 32'sh8000_0000, ST_DONE);
        add_item(REQ_READ, C_EZ, 1, 1, 1, 0, 0, 0, 1, 0, ST_REJECT);
        foreach (plan[r]) begin
            if (plan[r].is_cfg) write_size(plan[r].cfg_idx, plan[r].cfg_val);
            else send_word(plan[r].w, plan[r].has_exp, plan[r].exp_r);
        end

        // random phases over several grid sizes
        idle_on = 1'b1;
        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            write_size(CFG_SIZE_M, phases[ph % 8][0]);
            write_size(CFG_SIZE_N, phases[ph % 8][1]);
            write_size(CFG_SIZE_P, phases[ph % 8][2]);
            filled = axis_size(0) >= 3 && axis_size(1) >= 3 && axis_size(2) >= 3;
            if (filled) fill_grid();
            if (ph == 1) begin
                // long receiver hold-off while loads keep coming
                long_hold = 1'b1;
                for (int n = 0; n < 60; n++) send_word(pick_inside(REQ_LOAD), 1'b0, none);
                drain_words();
            end
            if (items_sent > ITEM_TARGET - 150) idle_on = 1'b0;
            random_mix(120, filled || !filled);
            ph++;
        end

        drain_words();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ysg_pkg.sv
rtl/core/ysg_ram.sv
rtl/core/ysg_mac.sv
rtl/core/yee_fdtd_grid_step.sv
tb/tb_yee_fdtd_grid_step.sv
